/* rtl/assert_macros.svh */
// Assertion helpers included by the checker in txd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that stays live through reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/txd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package txd_pkg;

   // pixel_format codes
   localparam logic [2:0] FMT_RGB565   = 3'd0;
   localparam logic [2:0] FMT_RGB555K  = 3'd1;
   localparam logic [2:0] FMT_ARGB4444 = 3'd2;
   localparam logic [2:0] FMT_RGB888   = 3'd3;
   localparam logic [2:0] FMT_BGRA8888 = 3'd4;
   localparam logic [2:0] FMT_DXT1     = 3'd5;
   localparam logic [2:0] FMT_DXT3     = 3'd6;

   // register indexes
   localparam logic CSR_PIXEL_FORMAT = 1'b0;
   localparam logic CSR_TRANS_KEY    = 1'b1;

   // channel slots inside a texel word
   localparam int CH_R = 3;
   localparam int CH_G = 2;
   localparam int CH_B = 1;
   localparam int CH_A = 0;

   localparam logic [3:0] LAST_INDEX = 4'd15;

   typedef logic [3:0][7:0] txd_rgba_type;

   typedef struct packed {
      logic [63:0] color_word;
      logic [63:0] alpha_word;
   } txd_req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [3:0] texel_index;
      logic       last_texel;
   } txd_rsp_type;

   typedef struct packed {
      logic         is_block;
      logic         is_dxt3;
      logic         four_color;
      txd_rgba_type ep0;
      txd_rgba_type ep1;
      logic [31:0]  codes;
      logic [63:0]  alpha_word;
      txd_rgba_type pixel;
   } txd_unpack_type;

   typedef struct packed {
      logic                    is_block;
      logic                    is_dxt3;
      txd_rgba_type [3:0]      pal;
      logic [31:0]             codes;
      logic [63:0]             alpha_word;
      txd_rgba_type            pixel;
   } txd_palette_type;

   function automatic logic [7:0] widen5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [7:0] widen6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   function automatic logic [7:0] widen4(input logic [3:0] v);
      return {v, v};
   endfunction

endpackage

`default_nettype wire

/* rtl/txd_unpack.sv */
`timescale 1ns / 1ps
`default_nettype none

module txd_unpack
   import txd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic [2:0]     pixel_format,
   input  logic [15:0]    trans_key,
   input  logic           in_valid,
   output logic           in_ready,
   input  txd_req_type    in_data,
   output logic           out_valid,
   input  logic           out_ready,
   output txd_unpack_type out_data
);

   logic           valid_ff;
   logic           valid_in;
   logic           keep;
   txd_unpack_type data_ff;
   txd_unpack_type data_in;
   logic [15:0]    c0;
   logic [15:0]    c1;
   logic [15:0]    v;
   logic [7:0]     b0, b1, b2, b3;

   assign in_ready = !valid_ff || out_ready;
   assign c0 = in_data.color_word[15:0];
   assign c1 = in_data.color_word[31:16];
   assign v  = in_data.color_word[15:0];
   assign b0 = in_data.color_word[7:0];
   assign b1 = in_data.color_word[15:8];
   assign b2 = in_data.color_word[23:16];
   assign b3 = in_data.color_word[31:24];

   always_comb begin
      keep = 1'b1;
      data_in.is_block   = 1'b0;
      data_in.is_dxt3    = (pixel_format == FMT_DXT3);
      data_in.four_color = (c0 > c1) || (pixel_format == FMT_DXT3);
      data_in.ep0[CH_R]  = widen5(c0[15:11]);
      data_in.ep0[CH_G]  = widen6(c0[10:5]);
      data_in.ep0[CH_B]  = widen5(c0[4:0]);
      data_in.ep0[CH_A]  = 8'hFF;
      data_in.ep1[CH_R]  = widen5(c1[15:11]);
      data_in.ep1[CH_G]  = widen6(c1[10:5]);
      data_in.ep1[CH_B]  = widen5(c1[4:0]);
      data_in.ep1[CH_A]  = 8'hFF;
      data_in.codes      = in_data.color_word[63:32];
      data_in.alpha_word = in_data.alpha_word;
      data_in.pixel      = '0;
      unique case (pixel_format) inside
         FMT_RGB565: begin
            data_in.pixel = {widen5(v[15:11]), widen6(v[10:5]), widen5(v[4:0]), 8'hFF};
         end
         FMT_RGB555K: begin
            data_in.pixel = {widen5(v[14:10]), widen5(v[9:5]), widen5(v[4:0]),
                             (v == trans_key) ? 8'h00 : 8'hFF};
         end
         FMT_ARGB4444: begin
            data_in.pixel = {widen4(v[11:8]), widen4(v[7:4]), widen4(v[3:0]),
                             widen4(v[15:12])};
         end
         FMT_RGB888: begin
            data_in.pixel = {b0, b1, b2, 8'hFF};
         end
         FMT_BGRA8888: begin
            data_in.pixel = {b2, b1, b0, b3};
         end
         FMT_DXT1, FMT_DXT3: begin
            data_in.is_block = 1'b1;
         end
         default: begin
            // unused code: drop the beat
            keep = 1'b0;
         end
      endcase
   end

   assign valid_in = in_valid && keep;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* rtl/txd_palette.sv */
`timescale 1ns / 1ps
`default_nettype none

module txd_palette
   import txd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  txd_unpack_type  in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output txd_palette_type out_data
);

   logic            valid_ff;
   txd_palette_type data_ff;
   txd_palette_type data_in;

   assign in_ready = !valid_ff || out_ready;

   // (2a+b+1)/3 by reciprocal: 683/2048 is exact for sums below 768
   function automatic logic [7:0] blend3(input logic [7:0] a, input logic [7:0] b);
      logic [9:0]  t;
      logic [20:0] prod;
      t    = {1'b0, a, 1'b0} + {2'b00, b} + 10'd1;
      prod = {11'd0, t} * 21'd683;
      return prod[18:11];
   endfunction

   always_comb begin
      logic [8:0] mid;
      data_in.is_block   = in_data.is_block;
      data_in.is_dxt3    = in_data.is_dxt3;
      data_in.codes      = in_data.codes;
      data_in.alpha_word = in_data.alpha_word;
      data_in.pixel      = in_data.pixel;
      data_in.pal[0]     = in_data.ep0;
      data_in.pal[1]     = in_data.ep1;
      data_in.pal[2]     = '0;
      data_in.pal[3]     = '0;
      for (int ch = CH_B; ch <= CH_R; ch++) begin
         mid = {1'b0, in_data.ep0[ch]} + {1'b0, in_data.ep1[ch]};
         if (in_data.four_color) begin
            data_in.pal[2][ch] = blend3(in_data.ep0[ch], in_data.ep1[ch]);
            data_in.pal[3][ch] = blend3(in_data.ep1[ch], in_data.ep0[ch]);
         end else begin
            data_in.pal[2][ch] = mid[8:1];
            data_in.pal[3][ch] = 8'h00;
         end
      end
      data_in.pal[2][CH_A] = 8'hFF;
      // punch-through: fourth entry is transparent black
      data_in.pal[3][CH_A] = in_data.four_color ? 8'hFF : 8'h00;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* rtl/txd_expand.sv */
`timescale 1ns / 1ps
`default_nettype none

module txd_expand
   import txd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  txd_palette_type in_data,
   output logic            out_valid,
   input  logic            out_stall,
   output txd_rsp_type     out_data
);

   logic            busy_ff;
   logic            busy_in;
   logic [3:0]      cnt_ff;
   logic [3:0]      cnt_in;
   txd_palette_type item_ff;
   logic            rsp_valid_ff;
   txd_rsp_type     rsp_data_ff;
   txd_rsp_type     rsp_data_in;
   logic            out_free;
   logic            emit;
   logic            last;
   logic            load;
   logic [1:0]      code;
   logic [3:0]      nibble;
   txd_rgba_type    entry;

   assign out_free = !rsp_valid_ff || !out_stall;
   assign emit     = busy_ff && out_free;
   assign last     = !item_ff.is_block || (cnt_ff == LAST_INDEX);
   assign in_ready = !busy_ff || (emit && last);
   assign load     = in_ready && in_valid;

   assign code   = item_ff.codes[{cnt_ff, 1'b0} +: 2];
   assign nibble = item_ff.alpha_word[{cnt_ff, 2'b00} +: 4];
   assign entry  = item_ff.is_block ? item_ff.pal[code] : item_ff.pixel;

   always_comb begin
      rsp_data_in.red         = entry[CH_R];
      rsp_data_in.green       = entry[CH_G];
      rsp_data_in.blue        = entry[CH_B];
      rsp_data_in.alpha       = (item_ff.is_block && item_ff.is_dxt3) ? widen4(nibble)
                                                                      : entry[CH_A];
      rsp_data_in.texel_index = cnt_ff;
      rsp_data_in.last_texel  = last;
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (emit) begin
         cnt_in = cnt_ff + 4'd1;
         if (last) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         if (out_free) begin
            rsp_valid_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= in_data;
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/texel_format_and_dxt_decoder_core.sv */
// Throughput while rsp is not stalled: a per-pixel beat yields one texel and one
// beat enters per cycle; a DXT block yields sixteen texels, one per cycle, so the
// next beat enters only in the cycle the block's last texel leaves,
// set by the single texel expander feeding the rsp output register.
// Reset: synchronous, active high; clears all valid bits, the expander and both
// registers (pixel_format rgb565, transparency key 0).
`timescale 1ns / 1ps
`default_nettype none

module texel_format_and_dxt_decoder_core
   import txd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  txd_req_type req_data,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output txd_rsp_type rsp_data,
   // register write port
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   // Pipeline: input register -> unpack (endpoint widening, per-pixel decode)
   // -> palette (1:2 / 2:1 blends or punch-through) -> expander + rsp register.
   // Each stage holds its beat while the next one is full and stalled.

   logic [2:0]      fmt_ff;
   logic [15:0]     key_ff;

   logic            s1_valid_ff;
   txd_req_type     s1_data_ff;

   logic            unp_ready;
   logic            unp_valid;
   txd_unpack_type  unp_data;
   logic            pal_ready;
   logic            pal_valid;
   txd_palette_type pal_data;
   logic            exp_ready;

   // The user must write the registers only while the pipeline is drained; the block itself does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_RGB565;
         key_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PIXEL_FORMAT: fmt_ff <= csr_wdata[2:0];
            CSR_TRANS_KEY:    key_ff <= csr_wdata;
            default:          fmt_ff <= fmt_ff;
         endcase
      end
   end

   // Input register: stall only when full and the unpack stage cannot take it.
   assign req_stall = s1_valid_ff && !unp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_data_ff <= req_data;
      end
   end

   // Unused format codes are dropped here and never reach rsp.
   txd_unpack u_unpack (
      .clock        (clock),
      .reset        (reset),
      .pixel_format (fmt_ff),
      .trans_key    (key_ff),
      .in_valid     (s1_valid_ff),
      .in_ready     (unp_ready),
      .in_data      (s1_data_ff),
      .out_valid    (unp_valid),
      .out_ready    (pal_ready),
      .out_data     (unp_data)
   );

   txd_palette u_palette (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (unp_valid),
      .in_ready  (pal_ready),
      .in_data   (unp_data),
      .out_valid (pal_valid),
      .out_ready (exp_ready),
      .out_data  (pal_data)
   );

   // Expander takes the next beat in the cycle its last texel moves out.
   txd_expand u_expand (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pal_valid),
      .in_ready  (exp_ready),
      .in_data   (pal_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* rtl/txd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module txd_checker
   import txd_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire txd_rsp_type rsp_data
);

   // Texels of a block follow each other with no gap and a rising index.
   `ASSERT_NEXT(a_block_sequence, clock, reset, rsp_valid && !rsp_stall && !rsp_data.last_texel, rsp_valid && (rsp_data.texel_index == 4'($past(rsp_data.texel_index) + 4'd1)), "texel index did not advance within a block")
   // Synchronous reset empties the result register.
   `ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid, "rsp_valid high after reset")
   // A stalled beat stays presented.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp_valid dropped under stall")
   // A stalled beat keeps its payload.
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data), "rsp_data changed under stall")

endmodule

bind texel_format_and_dxt_decoder_core txd_checker u_txd_checker (.*);

`default_nettype wire

/* dv/texel_checker.sv */
`timescale 1ns / 1ps

module texel_checker
   import txd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  txd_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  txd_rsp_type rsp_data,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          texels_outstanding
);

   localparam int MAX_REPORTS = 10;

   txd_rsp_type pending_texels[$];
   logic [2:0]  pixel_format = FMT_RGB565;
   logic [15:0] trans_key    = 16'h0000;
   int          mismatches   = 0;

   // bit replication written as integer scaling
   function automatic int grow5(input int v);
      return (v * 33) / 4;
   endfunction

   function automatic int grow6(input int v);
      return (v * 65) / 16;
   endfunction

   function automatic int grow4(input int v);
      return v * 17;
   endfunction

   function automatic txd_rsp_type make_texel(input int r, input int g, input int b,
                                              input int a, input int idx, input bit last);
      txd_rsp_type t;
      t.red         = 8'(r);
      t.green       = 8'(g);
      t.blue        = 8'(b);
      t.alpha       = 8'(a);
      t.texel_index = 4'(idx);
      t.last_texel  = last;
      return t;
   endfunction

   // Append one expected texel at the tail of the queue.
   function automatic void append_texel(input txd_rsp_type t);
      pending_texels.insert(pending_texels.size(), t);
   endfunction

   // Queue the texels one accepted request beat must produce.
   function automatic void decode_beat(input txd_req_type beat);
      logic [63:0] cw;
      logic [15:0] v;
      logic [15:0] c0;
      logic [15:0] c1;
      int          pal [4][4];
      int          code;
      int          a;
      int          i;
      int          ch;
      bit          four_color;
      cw = beat.color_word;
      v  = cw[15:0];
      c0 = cw[15:0];
      c1 = cw[31:16];
      case (pixel_format) inside
         FMT_RGB565: begin
            append_texel(make_texel(grow5(v[15:11]), grow6(v[10:5]),
                                    grow5(v[4:0]), 255, 0, 1'b1));
         end
         FMT_RGB555K: begin
            append_texel(make_texel(grow5(v[14:10]), grow5(v[9:5]),
                                    grow5(v[4:0]),
                                    (v == trans_key) ? 0 : 255, 0, 1'b1));
         end
         FMT_ARGB4444: begin
            append_texel(make_texel(grow4(v[11:8]), grow4(v[7:4]),
                                    grow4(v[3:0]), grow4(v[15:12]), 0, 1'b1));
         end
         FMT_RGB888: begin
            append_texel(make_texel(cw[7:0], cw[15:8], cw[23:16], 255, 0, 1'b1));
         end
         FMT_BGRA8888: begin
            append_texel(make_texel(cw[23:16], cw[15:8], cw[7:0], cw[31:24],
                                    0, 1'b1));
         end
         FMT_DXT1, FMT_DXT3: begin
            pal[0][0] = grow5(c0[15:11]);
            pal[0][1] = grow6(c0[10:5]);
            pal[0][2] = grow5(c0[4:0]);
            pal[1][0] = grow5(c1[15:11]);
            pal[1][1] = grow6(c1[10:5]);
            pal[1][2] = grow5(c1[4:0]);
            pal[0][3] = 255;
            pal[1][3] = 255;
            // DXT3 always blends 1:2 / 2:1; DXT1 punches through when c0 <= c1
            four_color = (c0 > c1) || (pixel_format == FMT_DXT3);
            for (ch = 0; ch < 3; ch++) begin
               if (four_color) begin
                  pal[2][ch] = (2 * pal[0][ch] + pal[1][ch] + 1) / 3;
                  pal[3][ch] = (pal[0][ch] + 2 * pal[1][ch] + 1) / 3;
               end else begin
                  pal[2][ch] = (pal[0][ch] + pal[1][ch]) / 2;
                  pal[3][ch] = 0;
               end
            end
            pal[2][3] = 255;
            pal[3][3] = four_color ? 255 : 0;
            for (i = 0; i < 16; i++) begin
               code = cw[32 + 2 * i +: 2];
               a = (pixel_format == FMT_DXT3) ? grow4(beat.alpha_word[4 * i +: 4])
                                              : pal[code][3];
               append_texel(make_texel(pal[code][0], pal[code][1],
                                       pal[code][2], a, i, i == 15));
            end
         end
         default: begin
            // unused format code: drop the beat
         end
      endcase
   endfunction

   always @(posedge clock) begin
      txd_rsp_type want;
      if (reset) begin
         pending_texels.delete();
         pixel_format = FMT_RGB565;
         trans_key    = 16'h0000;
      end else begin
         if (req_valid && !req_stall) begin
            decode_beat(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_texels.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display({"%t: texel with none outstanding: ",
                            "r %02x g %02x b %02x a %02x idx %0d last %0d"},
                           $realtime, rsp_data.red, rsp_data.green, rsp_data.blue,
                           rsp_data.alpha, rsp_data.texel_index, rsp_data.last_texel);
               end
            end else begin
               want = pending_texels.pop_front();
               if (rsp_data.red !== want.red || rsp_data.green !== want.green ||
                   rsp_data.blue !== want.blue || rsp_data.alpha !== want.alpha ||
                   rsp_data.texel_index !== want.texel_index ||
                   rsp_data.last_texel !== want.last_texel) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display({"%t: texel mismatch: expected ",
                               "r %02x g %02x b %02x a %02x idx %0d last %0d"},
                              $realtime, want.red, want.green, want.blue, want.alpha,
                              want.texel_index, want.last_texel);
                     $display({"%t:                 actual   ",
                               "r %02x g %02x b %02x a %02x idx %0d last %0d"},
                              $realtime, rsp_data.red, rsp_data.green, rsp_data.blue,
                              rsp_data.alpha, rsp_data.texel_index, rsp_data.last_texel);
                  end
               end
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_PIXEL_FORMAT) begin
               pixel_format = csr_wdata[2:0];
            end else begin
               trans_key = csr_wdata;
            end
         end
      end
      fail_count         <= mismatches;
      texels_outstanding <= pending_texels.size();
   end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import txd_pkg::*;

   // format code the block ignores: no texel comes out
   localparam logic [2:0] FMT_UNUSED = 3'd7;

   localparam int RANDOM_BEATS    = 360;
   localparam int SEGMENT_BEATS   = 30;
   localparam int PRESSURE_BEATS  = 40;
   localparam int PRESSURE_SEG    = 2;
   localparam int HOLD_OFF_CYCLES = 400;
   // pause after the last texel so that dropped beats also leave the pipe
   localparam int SETTLE_CYCLES   = 10;
   // longest quiet stretch in a correct run is the receiver hold-off plus a gap
   localparam int IDLE_LIMIT      = 3000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   txd_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   txd_rsp_type rsp_data;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;
   logic        pressure_on;

   int          fail_count;
   int          texels_outstanding;
   bit          sender_burst;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   texel_format_and_dxt_decoder_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   texel_checker texel_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data           (req_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data           (rsp_data),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .fail_count         (fail_count),
      .texels_outstanding (texels_outstanding)
   );

   // Offer one request beat after a random gap and hold it until it is taken.
   // Valid stays high into the next beat when that beat draws no gap.
   task automatic send_beat(input txd_req_type beat);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
   endtask

   // Write both registers on back-to-back edges; only call while the block is idle.
   // Junk goes into the unused upper bits of the format write.
   task automatic configure(input logic [2:0] fmt, input logic [15:0] key);
      csr_we    <= 1'b1;
      csr_index <= CSR_PIXEL_FORMAT;
      csr_wdata <= {13'($urandom), fmt};
      @(posedge clock);
      csr_index <= CSR_TRANS_KEY;
      csr_wdata <= key;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Drop valid, wait for every outstanding texel, then let the pipe drain
   // (covers beats of the unused format, which leave nothing to wait for).
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (texels_outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random beat with content steered toward the interesting corners of each format.
   function automatic txd_req_type random_beat(input logic [2:0] fmt, input logic [15:0] key);
      txd_req_type beat;
      beat.color_word = {$urandom, $urandom};
      beat.alpha_word = {$urandom, $urandom};
      case (fmt)
         FMT_RGB555K: begin
            // hit the key exactly, or miss it by one bit (bit 15 included)
            case ($urandom_range(0, 2))
               0: beat.color_word[15:0] = key;
               1: beat.color_word[15:0] = key ^ (16'h0001 << $urandom_range(0, 15));
               default: begin
               end
            endcase
         end
         FMT_DXT1, FMT_DXT3: begin
            // equal endpoints and extreme endpoints in either order
            case ($urandom_range(0, 3))
               0: beat.color_word[31:16] = beat.color_word[15:0];
               1: beat.color_word[31:0] = $urandom_range(0, 1) ? 32'h0000_FFFF
                                                               : 32'hFFFF_0000;
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
      return beat;
   endfunction

   // Result side: draw a stall for every texel, flip into and out of
   // no-stall stretches, and hold off once for a long time under pressure.
   initial begin : result_side
      int stall_cycles;
      bit burst;
      bit held;
      burst     = 1'b0;
      held      = 1'b0;
      rsp_stall = 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) begin
            burst = !burst;
         end
         if (pressure_on && !held) begin
            held         = 1'b1;
            stall_cycles = HOLD_OFF_CYCLES;
         end else begin
            stall_cycles = burst ? 0 : $urandom_range(0, 19);
         end
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid || rsp_stall);
      end
   end

   // Watchdog: end the run when nothing moves on either channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      int          seg;
      int          beats_done;
      int          count;
      int          i;
      logic [2:0]  fmt;
      logic [15:0] key;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_we       = 1'b0;
      csr_index    = CSR_PIXEL_FORMAT;
      csr_wdata    = 16'h0000;
      pressure_on  = 1'b0;
      sender_burst = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed beats: field extremes and every format, one register setting per group.
      configure(FMT_RGB565, 16'h0000);
      send_beat({64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000});
      send_beat({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
      send_beat({64'h0000_0000_0000_F81F, 64'h0000_0000_0000_0000});
      settle();

      // color key at its top value: exact match is transparent, bit 15 alone misses
      configure(FMT_RGB555K, 16'hFFFF);
      send_beat({64'h0000_0000_0000_FFFF, 64'h0000_0000_0000_0000});
      send_beat({64'h0000_0000_0000_7FFF, 64'h0000_0000_0000_0000});
      settle();

      // color key at zero, with garbage in the ignored upper bytes
      configure(FMT_RGB555K, 16'h0000);
      send_beat({64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000});
      send_beat({64'hFFFF_FFFF_FFFF_0000, 64'hFFFF_FFFF_FFFF_FFFF});
      settle();

      configure(FMT_ARGB4444, 16'h0000);
      send_beat({64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000});
      send_beat({64'h0000_0000_0000_FFFF, 64'h0000_0000_0000_0000});
      send_beat({64'hFFFF_FFFF_FFFF_5A3C, 64'h0000_0000_0000_0000});
      settle();

      configure(FMT_RGB888, 16'h0000);
      send_beat({64'h0000_0000_0012_3456, 64'h0000_0000_0000_0000});
      send_beat({64'hFFFF_FFFF_FF00_FF00, 64'h0000_0000_0000_0000});
      settle();

      configure(FMT_BGRA8888, 16'h0000);
      send_beat({64'h0000_0000_80FF_7F01, 64'h0000_0000_0000_0000});
      send_beat({64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000});
      settle();

      // DXT1: four-color block, punch-through with c0 < c1, and equal endpoints
      configure(FMT_DXT1, 16'h0000);
      send_beat({64'hE4E4_E4E4_0000_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
      send_beat({64'h1B1B_1B1B_FFFF_0000, 64'h0123_4567_89AB_CDEF});
      send_beat({64'hFFFF_FFFF_A5A5_A5A5, 64'h0000_0000_0000_0000});
      settle();

      // DXT3: four colors even when c0 <= c1; alpha from every nibble value
      configure(FMT_DXT3, 16'h0000);
      send_beat({64'hE4E4_E4E4_FFFF_0000, 64'hFEDC_BA98_7654_3210});
      send_beat({64'h1B1B_1B1B_07E0_F81F, 64'hFFFF_FFFF_FFFF_FFFF});
      send_beat({64'h9C9C_9C9C_5555_5555, 64'h0000_0000_0000_0000});
      settle();

      // unused format code: beats are swallowed without a texel
      configure(FMT_UNUSED, 16'h0000);
      send_beat({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
      send_beat({64'h0123_4567_89AB_CDEF, 64'h0000_0000_0000_0000});
      settle();

      // Random segments, each under its own register setting.
      seg        = 0;
      beats_done = 0;
      while (beats_done < RANDOM_BEATS) begin
         fmt = 3'($urandom_range(0, 7));
         key = 16'($urandom);
         if ($urandom_range(0, 3) == 0) begin
            key = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         end
         sender_burst = ($urandom_range(0, 3) == 0);
         count        = (fmt == FMT_UNUSED) ? 3 : SEGMENT_BEATS;
         if (seg == PRESSURE_SEG) begin
            // back-to-back beats while the receiver holds off: fill the block
            fmt          = FMT_RGB888;
            sender_burst = 1'b1;
            count        = PRESSURE_BEATS;
         end
         configure(fmt, key);
         if (seg == PRESSURE_SEG) begin
            pressure_on <= 1'b1;
         end
         for (i = 0; i < count; i++) begin
            send_beat(random_beat(fmt, key));
         end
         if (fmt != FMT_UNUSED) begin
            beats_done += count;
         end
         settle();
         seg++;
      end

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
